// ===== hw/rtl/fwpi_pkg.sv =====
// Shared types, widths and constants for the four-wheel incremental PI drive.
// No dependencies; imported by every module of the block.
package fwpi_pkg;

   // Block dimensions
   localparam int NUM_WHEELS   = 4;
   localparam int WHEEL_W      = 2;
   localparam int DRIVE_MAX    = 7200;
   localparam int ENCODER_BITS = 16;

   // Field widths
   localparam int VEL_W    = 11;
   localparam int ENC_W    = 16;
   localparam int BAT_W    = 16;
   localparam int GAIN_W   = 8;
   localparam int LIMIT_W  = 13;
   localparam int MAG_W    = 13;

   // Datapath widths
   localparam int DRIVE_W  = 14;
   localparam int TARGET_W = 13;
   localparam int ERR_W    = 17;
   localparam int DIFF_W   = 18;
   localparam int PTERM_W  = GAIN_W + 1 + DIFF_W;
   localparam int ITERM_W  = GAIN_W + 1 + ERR_W;
   localparam int SUM_W    = PTERM_W + 2;
   localparam int CLAMP_W  = DRIVE_W + 1;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_LIM  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_BATTERY = CSR_INDEX_W'(3);

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = GAIN_W'(10);
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = GAIN_W'(10);
   localparam logic [LIMIT_W-1:0] OUTPUT_LIM_RST  = LIMIT_W'(6900);
   localparam logic [BAT_W-1:0]   LOW_BATTERY_RST = BAT_W'(2000);

   // Wheel codes
   localparam logic [WHEEL_W-1:0] WHEEL_A = WHEEL_W'(0);
   localparam logic [WHEEL_W-1:0] WHEEL_B = WHEEL_W'(1);
   localparam logic [WHEEL_W-1:0] WHEEL_C = WHEEL_W'(2);
   localparam logic [WHEEL_W-1:0] WHEEL_D = WHEEL_W'(3);

   // Wheels whose direction bit is set on a negative drive (A and B)
   localparam logic [NUM_WHEELS-1:0] REV_ON_NEG = 4'b0011;

   typedef logic signed [DRIVE_W-1:0] drive_type;
   typedef logic signed [ERR_W-1:0]   err_type;

   // One entry of the per-wheel state memory
   typedef struct packed {
      drive_type drive;
      err_type   err;
   } state_entry_type;

   // One input transaction
   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_z;
      logic signed [ENC_W-1:0] count_a;
      logic signed [ENC_W-1:0] count_b;
      logic signed [ENC_W-1:0] count_c;
      logic signed [ENC_W-1:0] count_d;
      logic [BAT_W-1:0]        battery_level;
      logic                    drive_enable;
   } item_type;

   // Finished drives of one transaction, from the PI unit to the result buffer
   typedef struct packed {
      logic                        done;
      logic                        fault;
      drive_type [NUM_WHEELS-1:0]  drive;
   } pi_result_type;

   // One result transaction
   typedef struct packed {
      logic [NUM_WHEELS-1:0][MAG_W-1:0] magnitude;
      logic [NUM_WHEELS-1:0]            reverse;
      logic                             power_fault;
   } rsp_type;

endpackage

// ===== hw/rtl/fwpi_state_mem.sv =====
// Per-wheel PI state memory: accumulated drive and previous error.
// Synchronous registered read; entries read as zero until written.
// Depends on fwpi_pkg.
module fwpi_state_mem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [fwpi_pkg::WHEEL_W-1:0]   rd_addr,
   output fwpi_pkg::state_entry_type      rd_data,
   input  logic                           wr_en,
   input  logic [fwpi_pkg::WHEEL_W-1:0]   wr_addr,
   input  fwpi_pkg::state_entry_type      wr_data
);
   import fwpi_pkg::*;

   state_entry_type       state_ram [NUM_WHEELS];
   logic [NUM_WHEELS-1:0] valid_ff;
   logic [NUM_WHEELS-1:0] valid_in;
   state_entry_type       rd_data_ff;
   logic                  rd_valid_ff;

   // Mark entries written since reset
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_ram[wr_addr] <= wr_data;
      end
      rd_data_ff <= state_ram[rd_addr];
   end

   // Unwritten entries hold the reset value of zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/fwpi_pi_unit.sv =====
// Shared PI update unit: one wheel per cycle through mix, multiply and
// accumulate stages, with read-modify-write of the per-wheel state memory.
// Depends on fwpi_pkg and fwpi_state_mem.
module fwpi_pi_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           issue,
   input  logic [fwpi_pkg::WHEEL_W-1:0]   wheel,
   input  fwpi_pkg::item_type             item,
   input  logic [fwpi_pkg::GAIN_W-1:0]    prop_gain,
   input  logic [fwpi_pkg::GAIN_W-1:0]    integ_gain,
   input  logic [fwpi_pkg::BAT_W-1:0]     low_battery_level,
   output fwpi_pkg::pi_result_type        result
);
   import fwpi_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(DRIVE_MAX);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(DRIVE_MAX);

   // Stage 0: mix and error
   logic signed [ENCODER_BITS-1:0] enc_sel;
   logic signed [TARGET_W-1:0]     vx;
   logic signed [TARGET_W-1:0]     vy;
   logic signed [TARGET_W-1:0]     vz;
   logic signed [TARGET_W-1:0]     target;
   err_type                        err0;
   logic                           fault0;

   // Stage 1 registers
   logic                  v1_ff;
   logic [WHEEL_W-1:0]    wheel1_ff;
   err_type               err1_ff;
   logic                  fault1_ff;
   state_entry_type       rd_data;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [GAIN_W:0]    kp_s;
   logic signed [GAIN_W:0]    ki_s;
   logic signed [PTERM_W-1:0] pterm;
   logic signed [ITERM_W-1:0] iterm;

   // Stage 2 registers
   logic                      v2_ff;
   logic [WHEEL_W-1:0]        wheel2_ff;
   err_type                   err2_ff;
   logic                      fault2_ff;
   drive_type                 acc2_ff;
   logic signed [PTERM_W-1:0] pterm2_ff;
   logic signed [ITERM_W-1:0] iterm2_ff;
   logic signed [SUM_W-1:0]   sum;
   drive_type                 sat;
   state_entry_type           wr_data;

   // Collected drives of the transaction in flight
   drive_type drive_ff [NUM_WHEELS];
   logic      done_ff;
   logic      fault_ff;

   // Mix the body command into the selected wheel's target
   always_comb begin
      vx = TARGET_W'(item.vel_x);
      vy = TARGET_W'(item.vel_y);
      vz = TARGET_W'(item.vel_z);
      case (wheel)
         WHEEL_A: begin
            enc_sel = item.count_a[ENCODER_BITS-1:0];
            target  = -vx + vy + vz;
         end
         WHEEL_B: begin
            enc_sel = item.count_b[ENCODER_BITS-1:0];
            target  = vx + vy - vz;
         end
         WHEEL_C: begin
            enc_sel = item.count_c[ENCODER_BITS-1:0];
            target  = -vx + vy - vz;
         end
         default: begin
            enc_sel = item.count_d[ENCODER_BITS-1:0];
            target  = vx + vy + vz;
         end
      endcase
      err0   = ERR_W'(enc_sel) - ERR_W'(target);
      fault0 = (item.battery_level < low_battery_level) || !item.drive_enable;
   end

   // Read the wheel's state while the error is registered
   fwpi_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (wheel),
      .rd_data (rd_data),
      .wr_en   (v2_ff),
      .wr_addr (wheel2_ff),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
      end
      wheel1_ff <= wheel;
      err1_ff   <= err0;
      fault1_ff <= fault0;
   end

   // Stage 1: proportional and integral products
   always_comb begin
      kp_s  = {1'b0, prop_gain};
      ki_s  = {1'b0, integ_gain};
      diff  = DIFF_W'(err1_ff) - DIFF_W'(rd_data.err);
      pterm = kp_s * diff;
      iterm = ki_s * err1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      wheel2_ff <= wheel1_ff;
      err2_ff   <= err1_ff;
      fault2_ff <= fault1_ff;
      acc2_ff   <= rd_data.drive;
      pterm2_ff <= pterm;
      iterm2_ff <= iterm;
   end

   // Stage 2: accumulate, saturate and write back
   always_comb begin
      sum = SUM_W'(acc2_ff) + SUM_W'(pterm2_ff) + SUM_W'(iterm2_ff);
      if (sum > SAT_HI) begin
         sat = DRIVE_W'(SAT_HI);
      end else if (sum < SAT_LO) begin
         sat = DRIVE_W'(SAT_LO);
      end else begin
         sat = DRIVE_W'(sum);
      end
      wr_data.drive = sat;
      wr_data.err   = err2_ff;
   end

   // Collect drives; flag completion after the last wheel
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= v2_ff && (wheel2_ff == WHEEL_D);
      end
      if (v2_ff) begin
         drive_ff[wheel2_ff] <= sat;
      end
      if (v2_ff && (wheel2_ff == WHEEL_D)) begin
         fault_ff <= fault2_ff;
      end
   end

   always_comb begin
      result.done  = done_ff;
      result.fault = fault_ff;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         result.drive[i] = drive_ff[i];
      end
   end

endmodule

// ===== hw/rtl/fwpi_rsp_buf.sv =====
// Result formatting and buffering: output clamp, sign/magnitude split and a
// two-deep buffer (output register plus one spare) toward the result channel.
// Depends on fwpi_pkg.
module fwpi_rsp_buf (
   input  logic                           clock,
   input  logic                           reset,
   input  fwpi_pkg::pi_result_type        result,
   input  logic [fwpi_pkg::LIMIT_W-1:0]   output_limit,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output fwpi_pkg::rsp_type              rsp_data
);
   import fwpi_pkg::*;

   rsp_type                    fmt;
   logic signed [CLAMP_W-1:0]  lim_hi;
   logic signed [CLAMP_W-1:0]  lim_lo;
   logic signed [CLAMP_W-1:0]  drv;
   logic signed [CLAMP_W-1:0]  clamped;
   logic [CLAMP_W-1:0]         abs_val;

   rsp_type rsp_ff;
   logic    rsp_vld_ff;
   rsp_type pend_ff;
   logic    pend_vld_ff;
   logic    rsp_free;

   // Clamp each drive and split into magnitude and direction
   always_comb begin
      lim_hi  = CLAMP_W'(output_limit);
      lim_lo  = -lim_hi;
      drv     = '0;
      clamped = '0;
      abs_val = '0;
      fmt     = '0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         drv = CLAMP_W'($signed(result.drive[i]));
         if (drv > lim_hi) begin
            clamped = lim_hi;
         end else if (drv < lim_lo) begin
            clamped = lim_lo;
         end else begin
            clamped = drv;
         end
         abs_val = clamped[CLAMP_W-1] ? CLAMP_W'(-clamped) : CLAMP_W'(clamped);
         fmt.magnitude[i] = result.fault ? '0 : abs_val[MAG_W-1:0];
         fmt.reverse[i]   = REV_ON_NEG[i] ? clamped[CLAMP_W-1]
                                          : (!clamped[CLAMP_W-1] && (clamped != '0));
      end
      fmt.power_fault = result.fault;
   end

   assign rsp_free = !rsp_vld_ff || !rsp_stall;

   // Advance the spare into the output register; park a result when stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else if (rsp_free) begin
         if (pend_vld_ff) begin
            rsp_vld_ff  <= 1'b1;
            pend_vld_ff <= result.done;
         end else begin
            rsp_vld_ff  <= result.done;
         end
      end else if (result.done) begin
         pend_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (pend_vld_ff) begin
            rsp_ff <= pend_ff;
            if (result.done) begin
               pend_ff <= fmt;
            end
         end else if (result.done) begin
            rsp_ff <= fmt;
         end
      end else if (result.done) begin
         pend_ff <= fmt;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/four_wheel_incremental_pi_drive.sv =====
// Top level of the four-wheel incremental PI drive: input register, wheel
// sequencer, configuration registers and result credit count.
// Depends on fwpi_pkg, fwpi_pi_unit and fwpi_rsp_buf.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid / req_stall velocity command, wheel counts, battery, enable
//   rsp_     out        rsp_valid / rsp_stall four magnitudes, four reverse bits, fault
//   csr_     in         csr_valid / csr_ready register index and write data
//
// A transaction passes one wheel per cycle, once a result credit is free, through the shared PI unit
// and the single read and write port of the state memory; the next transaction is
// accepted as the last wheel of the current one issues.
// Reset clears the control state; the state memory reads as zero through its
// per-entry valid bits, so no clearing pass is needed. Up to two finished
// results are held while rsp_stall is high; a third transaction then waits in
// the input register with req_stall high.
module four_wheel_incremental_pi_drive (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fwpi_pkg::VEL_W-1:0]   req_vel_x,
   input  logic signed [fwpi_pkg::VEL_W-1:0]   req_vel_y,
   input  logic signed [fwpi_pkg::VEL_W-1:0]   req_vel_z,
   input  logic signed [fwpi_pkg::ENC_W-1:0]   req_count_a,
   input  logic signed [fwpi_pkg::ENC_W-1:0]   req_count_b,
   input  logic signed [fwpi_pkg::ENC_W-1:0]   req_count_c,
   input  logic signed [fwpi_pkg::ENC_W-1:0]   req_count_d,
   input  logic [fwpi_pkg::BAT_W-1:0]          req_battery_level,
   input  logic                                req_drive_enable,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fwpi_pkg::MAG_W-1:0]          rsp_magnitude_a,
   output logic                                rsp_reverse_a,
   output logic [fwpi_pkg::MAG_W-1:0]          rsp_magnitude_b,
   output logic                                rsp_reverse_b,
   output logic [fwpi_pkg::MAG_W-1:0]          rsp_magnitude_c,
   output logic                                rsp_reverse_c,
   output logic [fwpi_pkg::MAG_W-1:0]          rsp_magnitude_d,
   output logic                                rsp_reverse_d,
   output logic                                rsp_power_fault,
   // Configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fwpi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fwpi_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fwpi_pkg::*;

   // Configuration registers
   logic [GAIN_W-1:0]  prop_gain_ff;
   logic [GAIN_W-1:0]  integ_gain_ff;
   logic [LIMIT_W-1:0] output_limit_ff;
   logic [BAT_W-1:0]   low_battery_ff;

   // Input register and sequencer
   item_type           item_ff;
   item_type           req_item;
   logic               item_vld_ff;
   logic               item_vld_in;
   logic [WHEEL_W-1:0] wheel_ff;
   logic [WHEEL_W-1:0] wheel_in;
   logic [1:0]         credit_ff;
   logic [1:0]         credit_in;
   logic               issue;
   logic               last_issue;
   logic               start;
   logic               accept;
   logic               rsp_taken;
   logic               credit_ok;

   pi_result_type      pi_result;
   rsp_type            rsp_data;

   // Write configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= PROP_GAIN_RST;
         integ_gain_ff   <= INTEG_GAIN_RST;
         output_limit_ff <= OUTPUT_LIM_RST;
         low_battery_ff  <= LOW_BATTERY_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROP_GAIN:   prop_gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_INTEG_GAIN:  integ_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_OUTPUT_LIM:  output_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_LOW_BATTERY: low_battery_ff  <= csr_wdata[BAT_W-1:0];
            default: ;
         endcase
      end
   end

   // Gather the input fields
   always_comb begin
      req_item.vel_x         = req_vel_x;
      req_item.vel_y         = req_vel_y;
      req_item.vel_z         = req_vel_z;
      req_item.count_a       = req_count_a;
      req_item.count_b       = req_count_b;
      req_item.count_c       = req_count_c;
      req_item.count_d       = req_count_d;
      req_item.battery_level = req_battery_level;
      req_item.drive_enable  = req_drive_enable;
   end

   // Start a transaction only when a result slot is sure to be free
   assign rsp_taken  = rsp_valid && !rsp_stall;
   assign credit_ok  = (credit_ff < 2'd2) || rsp_taken;
   assign issue      = item_vld_ff && ((wheel_ff != WHEEL_A) || credit_ok);
   assign start      = issue && (wheel_ff == WHEEL_A);
   assign last_issue = issue && (wheel_ff == WHEEL_D);
   assign req_stall  = item_vld_ff && !last_issue;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      item_vld_in = item_vld_ff;
      if (accept) begin
         item_vld_in = 1'b1;
      end else if (last_issue) begin
         item_vld_in = 1'b0;
      end
      wheel_in  = issue ? wheel_ff + WHEEL_W'(1) : wheel_ff;
      credit_in = credit_ff + {1'b0, start} - {1'b0, rsp_taken};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         wheel_ff    <= WHEEL_A;
         credit_ff   <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         wheel_ff    <= wheel_in;
         credit_ff   <= credit_in;
      end
      if (accept) begin
         item_ff <= req_item;
      end
   end

   fwpi_pi_unit u_pi_unit (
      .clock             (clock),
      .reset             (reset),
      .issue             (issue),
      .wheel             (wheel_ff),
      .item              (item_ff),
      .prop_gain         (prop_gain_ff),
      .integ_gain        (integ_gain_ff),
      .low_battery_level (low_battery_ff),
      .result            (pi_result)
   );

   fwpi_rsp_buf u_rsp_buf (
      .clock        (clock),
      .reset        (reset),
      .result       (pi_result),
      .output_limit (output_limit_ff),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

   // Drive the result fields
   assign rsp_magnitude_a = rsp_data.magnitude[WHEEL_A];
   assign rsp_reverse_a   = rsp_data.reverse[WHEEL_A];
   assign rsp_magnitude_b = rsp_data.magnitude[WHEEL_B];
   assign rsp_reverse_b   = rsp_data.reverse[WHEEL_B];
   assign rsp_magnitude_c = rsp_data.magnitude[WHEEL_C];
   assign rsp_reverse_c   = rsp_data.reverse[WHEEL_C];
   assign rsp_magnitude_d = rsp_data.magnitude[WHEEL_D];
   assign rsp_reverse_d   = rsp_data.reverse[WHEEL_D];
   assign rsp_power_fault = rsp_data.power_fault;

endmodule

// ===== bench/four_wheel_incremental_pi_drive_tb.sv =====
// Testbench for the four-wheel incremental PI drive: directed and random control ticks under several
// register settings and idle patterns, each result checked against a local PI model or a typed-in result.
// Depends on fwpi_pkg and four_wheel_incremental_pi_drive.
module four_wheel_incremental_pi_drive_tb;
   import fwpi_pkg::*;

   localparam int RSP_LATENCY     = 7;
   localparam int SETTLE_CYCLES   = RSP_LATENCY + 5;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int NUM_PHASES      = 10;
   localparam int TICKS_PER_PHASE = 193;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_data;
      item_type               tick;
      logic                   pinned;
      rsp_type                result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid         = 1'b0;
   logic                    req_stall;
   logic signed [VEL_W-1:0] req_vel_x         = '0;
   logic signed [VEL_W-1:0] req_vel_y         = '0;
   logic signed [VEL_W-1:0] req_vel_z         = '0;
   logic signed [ENC_W-1:0] req_count_a       = '0;
   logic signed [ENC_W-1:0] req_count_b       = '0;
   logic signed [ENC_W-1:0] req_count_c       = '0;
   logic signed [ENC_W-1:0] req_count_d       = '0;
   logic [BAT_W-1:0]        req_battery_level = '0;
   logic                    req_drive_enable  = 1'b0;

   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [MAG_W-1:0] rsp_magnitude_a, rsp_magnitude_b, rsp_magnitude_c, rsp_magnitude_d;
   logic             rsp_reverse_a, rsp_reverse_b, rsp_reverse_c, rsp_reverse_d;
   logic             rsp_power_fault;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Typed-in result that travels with the tick being offered
   logic    pin_valid  = 1'b0;
   rsp_type pin_result = '0;

   // Local copy of the registers and the per-wheel PI state
   logic [GAIN_W-1:0]  prop_gain_cfg;
   logic [GAIN_W-1:0]  integ_gain_cfg;
   logic [LIMIT_W-1:0] output_limit_cfg;
   logic [BAT_W-1:0]   low_battery_cfg;
   drive_type          wheel_drive [NUM_WHEELS];
   err_type            wheel_err   [NUM_WHEELS];

   rsp_type      pending_ticks [$];
   stim_row_type directed_rows [$];
   int        mismatches     = 0;
   int        cur_low_bat    = 2000;
   int        send_idle_pct  = 0;
   int        stall_pct      = 0;
   logic      hold_off_armed = 1'b0;
   logic      hold_off_used  = 1'b0;
   int        held_cycles    = 0;
   int        quiet_cycles   = 0;

   four_wheel_incremental_pi_drive dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_vel_x         (req_vel_x),
      .req_vel_y         (req_vel_y),
      .req_vel_z         (req_vel_z),
      .req_count_a       (req_count_a),
      .req_count_b       (req_count_b),
      .req_count_c       (req_count_c),
      .req_count_d       (req_count_d),
      .req_battery_level (req_battery_level),
      .req_drive_enable  (req_drive_enable),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_magnitude_a   (rsp_magnitude_a),
      .rsp_reverse_a     (rsp_reverse_a),
      .rsp_magnitude_b   (rsp_magnitude_b),
      .rsp_reverse_b     (rsp_reverse_b),
      .rsp_magnitude_c   (rsp_magnitude_c),
      .rsp_reverse_c     (rsp_reverse_c),
      .rsp_magnitude_d   (rsp_magnitude_d),
      .rsp_reverse_d     (rsp_reverse_d),
      .rsp_power_fault   (rsp_power_fault),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mix the command, run one PI update per wheel and split the clamped drive
   function automatic rsp_type pi_tick(item_type it);
      rsp_type r;
      longint  vx, vy, vz, err, sum, drv;
      longint  target [NUM_WHEELS];
      longint  enc    [NUM_WHEELS];
      logic    fault;
      vx = $signed(it.vel_x);
      vy = $signed(it.vel_y);
      vz = $signed(it.vel_z);
      target[WHEEL_A] = -vx + vy + vz;
      target[WHEEL_B] =  vx + vy - vz;
      target[WHEEL_C] = -vx + vy - vz;
      target[WHEEL_D] =  vx + vy + vz;
      enc[WHEEL_A] = $signed(it.count_a);
      enc[WHEEL_B] = $signed(it.count_b);
      enc[WHEEL_C] = $signed(it.count_c);
      enc[WHEEL_D] = $signed(it.count_d);
      fault = (it.battery_level < low_battery_cfg) || !it.drive_enable;
      r.power_fault = fault;
      for (int w = 0; w < NUM_WHEELS; w++) begin
         err = enc[w] - target[w];
         sum = longint'(wheel_drive[w])
               + longint'(prop_gain_cfg) * (err - longint'(wheel_err[w]))
               + longint'(integ_gain_cfg) * err;
         if (sum > DRIVE_MAX) begin
            sum = DRIVE_MAX;
         end else if (sum < -DRIVE_MAX) begin
            sum = -DRIVE_MAX;
         end
         wheel_drive[w] = drive_type'(sum);
         wheel_err[w]   = err_type'(err);
         drv = sum;
         if (drv > longint'(output_limit_cfg)) begin
            drv = longint'(output_limit_cfg);
         end else if (drv < -longint'(output_limit_cfg)) begin
            drv = -longint'(output_limit_cfg);
         end
         r.reverse[w]   = REV_ON_NEG[w] ? (drv < 0) : (drv > 0);
         r.magnitude[w] = fault ? '0 : MAG_W'(drv < 0 ? -drv : drv);
      end
      return r;
   endfunction

   function automatic item_type tick_of(int vx, int vy, int vz, int ea, int eb, int ec,
                                        int ed, int bat, logic en);
      item_type it;
      it.vel_x         = VEL_W'(vx);
      it.vel_y         = VEL_W'(vy);
      it.vel_z         = VEL_W'(vz);
      it.count_a       = ENC_W'(ea);
      it.count_b       = ENC_W'(eb);
      it.count_c       = ENC_W'(ec);
      it.count_d       = ENC_W'(ed);
      it.battery_level = BAT_W'(bat);
      it.drive_enable  = en;
      return it;
   endfunction

   // Direction bits are given as {D, C, B, A}
   function automatic rsp_type result_of(int ma, int mb, int mc, int md, logic [3:0] rev,
                                         logic fault);
      rsp_type r;
      r.magnitude[WHEEL_A] = MAG_W'(ma);
      r.magnitude[WHEEL_B] = MAG_W'(mb);
      r.magnitude[WHEEL_C] = MAG_W'(mc);
      r.magnitude[WHEEL_D] = MAG_W'(md);
      r.reverse            = rev;
      r.power_fault        = fault;
      return r;
   endfunction

   function automatic void add_tick(item_type it);
      directed_rows.push_back('{ROW_TICK, '0, '0, it, 1'b0, '0});
   endfunction

   function automatic void add_pinned(item_type it, rsp_type res);
      directed_rows.push_back('{ROW_TICK, '0, '0, it, 1'b1, res});
   endfunction

   function automatic void add_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      directed_rows.push_back('{ROW_WRITE, idx, data, '0, 1'b0, '0});
   endfunction

   task automatic check_field(string name, logic [MAG_W-1:0] want_v, logic [MAG_W-1:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         mismatches++;
      end
   endtask

   // Check results, mirror register writes and predict each accepted tick
   always @(posedge clock) begin : scoreboard
      rsp_type  want;
      item_type seen;
      if (reset) begin
         prop_gain_cfg    = PROP_GAIN_RST;
         integ_gain_cfg   = INTEG_GAIN_RST;
         output_limit_cfg = OUTPUT_LIM_RST;
         low_battery_cfg  = LOW_BATTERY_RST;
         for (int w = 0; w < NUM_WHEELS; w++) begin
            wheel_drive[w] = '0;
            wheel_err[w]   = '0;
         end
         pending_ticks.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_ticks.size() == 0) begin
               $error("rsp transaction with no tick pending");
               mismatches++;
            end else begin
               want = pending_ticks.pop_front();
               check_field("magnitude_a", want.magnitude[WHEEL_A], rsp_magnitude_a);
               check_field("reverse_a", MAG_W'(want.reverse[WHEEL_A]), MAG_W'(rsp_reverse_a));
               check_field("magnitude_b", want.magnitude[WHEEL_B], rsp_magnitude_b);
               check_field("reverse_b", MAG_W'(want.reverse[WHEEL_B]), MAG_W'(rsp_reverse_b));
               check_field("magnitude_c", want.magnitude[WHEEL_C], rsp_magnitude_c);
               check_field("reverse_c", MAG_W'(want.reverse[WHEEL_C]), MAG_W'(rsp_reverse_c));
               check_field("magnitude_d", want.magnitude[WHEEL_D], rsp_magnitude_d);
               check_field("reverse_d", MAG_W'(want.reverse[WHEEL_D]), MAG_W'(rsp_reverse_d));
               check_field("power_fault", MAG_W'(want.power_fault), MAG_W'(rsp_power_fault));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROP_GAIN:   prop_gain_cfg    = csr_wdata[GAIN_W-1:0];
               CSR_INTEG_GAIN:  integ_gain_cfg   = csr_wdata[GAIN_W-1:0];
               CSR_OUTPUT_LIM:  output_limit_cfg = csr_wdata[LIMIT_W-1:0];
               CSR_LOW_BATTERY: low_battery_cfg  = csr_wdata[BAT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            seen = '{req_vel_x, req_vel_y, req_vel_z, req_count_a, req_count_b,
                     req_count_c, req_count_d, req_battery_level, req_drive_enable};
            // advance the PI state even when the result is typed in
            want = pi_tick(seen);
            if (pin_valid) begin
               want = pin_result;
            end
            pending_ticks.push_back(want);
         end
      end
   end

   // Stall the result channel at random; hold off once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_armed && !hold_off_used) begin
         rsp_stall <= 1'b1;
         held_cycles++;
         if (held_cycles == HOLD_OFF_CYCLES) begin
            hold_off_used = 1'b1;
         end
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one tick, after an optional gap, and hold it until accepted
   task automatic send_tick(item_type it, logic pin, rsp_type res);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_vel_x         <= it.vel_x;
      req_vel_y         <= it.vel_y;
      req_vel_z         <= it.vel_z;
      req_count_a       <= it.count_a;
      req_count_b       <= it.count_b;
      req_count_c       <= it.count_c;
      req_count_d       <= it.count_d;
      req_battery_level <= it.battery_level;
      req_drive_enable  <= it.drive_enable;
      pin_valid         <= pin;
      pin_result        <= res;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every pending result, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers; unused upper data bits carry junk
   task automatic configure(int unsigned kp, int unsigned ki, int unsigned lim,
                            int unsigned low_bat);
      logic [7:0] junk;
      settle();
      junk = 8'($urandom);
      write_reg(CSR_PROP_GAIN, {junk, kp[7:0]});
      junk = 8'($urandom);
      write_reg(CSR_INTEG_GAIN, {junk, ki[7:0]});
      junk = 8'($urandom);
      write_reg(CSR_OUTPUT_LIM, {junk[2:0], lim[12:0]});
      write_reg(CSR_LOW_BATTERY, low_bat[15:0]);
      cur_low_bat = low_bat;
   endtask

   initial begin : stimulus
      item_type      it;
      logic [127:0]  noise_bits;
      idle_mode_type mode;
      int            vx, vy, vz, bat, spread;
      int            wobble [NUM_WHEELS];
      int unsigned   kp, ki, lim, low_bat;

      // Resting, saturation both ways and forced-off cases from a cleared state
      add_pinned(tick_of(0, 0, 0, 0, 0, 0, 0, 4000, 1'b1),
                 result_of(0, 0, 0, 0, 4'b0000, 1'b0));
      add_pinned(tick_of(0, 0, 0, 32767, 32767, 32767, 32767, 4000, 1'b1),
                 result_of(6900, 6900, 6900, 6900, 4'b1100, 1'b0));
      add_pinned(tick_of(0, 0, 0, -32768, -32768, -32768, -32768, 65535, 1'b1),
                 result_of(6900, 6900, 6900, 6900, 4'b0011, 1'b0));
      add_pinned(tick_of(0, 0, 0, 0, 0, 0, 0, 4000, 1'b0),
                 result_of(0, 0, 0, 0, 4'b1100, 1'b1));
      add_pinned(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 1'b1),
                 result_of(0, 0, 0, 0, 4'b1100, 1'b1));
      // Command extremes and the battery threshold
      add_tick(tick_of(-1024, 1023, 1023, 0, 0, 0, 0, 1999, 1'b1));
      add_tick(tick_of(1023, -1024, -1024, 100, -100, 50, -50, 2000, 1'b1));
      add_tick(tick_of(-1024, -1024, -1024, 3071, -1024, 1024, -3072, 65535, 1'b1));
      add_tick(tick_of(1023, 1023, 1023, -32768, 32767, 0, -1, 2001, 1'b1));
      add_tick(tick_of(5, -3, 2, 4, -2, -9, 4, 3000, 1'b1));
      add_tick(tick_of(5, -3, 2, 4, -2, -9, 4, 3000, 1'b1));
      // Zero limit: nothing drives and no direction is shown
      add_write(CSR_OUTPUT_LIM, 16'h0000);
      add_pinned(tick_of(0, 0, 0, 32767, 32767, 32767, 32767, 4000, 1'b1),
                 result_of(0, 0, 0, 0, 4'b0000, 1'b0));
      add_pinned(tick_of(0, 0, 0, -32768, -32768, -32768, -32768, 4000, 1'b0),
                 result_of(0, 0, 0, 0, 4'b0000, 1'b1));
      // Limit above the saturation level: the drive tops out at DRIVE_MAX
      add_write(CSR_OUTPUT_LIM, 16'hFFFF);
      add_pinned(tick_of(0, 0, 0, 32767, 32767, 32767, 32767, 4000, 1'b1),
                 result_of(7200, 7200, 7200, 7200, 4'b1100, 1'b0));
      add_pinned(tick_of(0, 0, 0, -32768, -32768, -32768, -32768, 4000, 1'b1),
                 result_of(7200, 7200, 7200, 7200, 4'b0011, 1'b0));
      // Gain extremes and the highest battery threshold
      add_write(CSR_PROP_GAIN, 16'hFFFF);
      add_write(CSR_INTEG_GAIN, 16'hFF00);
      add_write(CSR_LOW_BATTERY, 16'hFFFF);
      add_write(CSR_OUTPUT_LIM, 16'd7200);
      add_tick(tick_of(0, 0, 0, 1, -1, 1000, -1000, 65535, 1'b1));
      add_tick(tick_of(0, 0, 0, 1, -1, 1000, -1000, 65534, 1'b1));
      add_tick(tick_of(17, -40, 300, -280, 620, -340, 277, 65535, 1'b1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
         end else begin
            send_tick(directed_rows[i].tick, directed_rows[i].pinned, directed_rows[i].result);
         end
      end

      // Random phases, each with its own register setting and idle pattern
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: configure(10, 10, 6900, 2000);
            1: configure(0, 0, 7200, 0);
            2: configure(255, 255, 8191, 65535);
            3: configure(1, 1, 0, 1000);
            default: begin
               kp      = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 255);
               ki      = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 255);
               lim     = $urandom_range(0, 3) ? $urandom_range(0, 7200) : $urandom_range(0, 8191);
               low_bat = $urandom_range(0, 5000);
               configure(kp, ki, lim, low_bat);
            end
         endcase
         mode = idle_mode_type'(p % 4);
         case (mode)
            IDLE_NONE: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            IDLE_SENDER: begin
               send_idle_pct = 48;
               stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct = 0;
               stall_pct <= 48;
            end
            default: begin
               send_idle_pct = 11;
               stall_pct <= 11;
            end
         endcase
         // hold off the results while the sender keeps offering ticks
         if (p == 4) begin
            hold_off_armed <= 1'b1;
         end
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) < 2) begin
               noise_bits = {$urandom, $urandom, $urandom, $urandom};
               it = noise_bits[$bits(item_type)-1:0];
            end else begin
               // wheel counts track the wheel targets with a small or a wide error
               vx = $urandom_range(0, 800) - 400;
               vy = $urandom_range(0, 800) - 400;
               vz = $urandom_range(0, 800) - 400;
               spread = ($urandom_range(0, 3) == 0) ? 2000 : 40;
               for (int w = 0; w < NUM_WHEELS; w++) begin
                  wobble[w] = int'($urandom_range(0, 2 * spread)) - spread;
               end
               bat = cur_low_bat + int'($urandom_range(0, 400)) - 100;
               if ($urandom_range(0, 4) == 0) begin
                  bat = $urandom_range(0, 65535);
               end
               if (bat < 0) begin
                  bat = 0;
               end else if (bat > 65535) begin
                  bat = 65535;
               end
               it = tick_of(vx, vy, vz, -vx + vy + vz + wobble[0], vx + vy - vz + wobble[1],
                            -vx + vy - vz + wobble[2], vx + vy + vz + wobble[3], bat,
                            $urandom_range(0, 15) != 0);
            end
            send_tick(it, 1'b0, '0);
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
